// ===== hdl/bitmap_contiguous_run_allocator_defines.svh =====
// Assertion macros used by the checker file of the run allocator.
`ifndef BITMAP_CONTIGUOUS_RUN_ALLOCATOR_DEFINES_SVH
`define BITMAP_CONTIGUOUS_RUN_ALLOCATOR_DEFINES_SVH

// Clocked assertion that is switched off while reset is held.
`define BCRA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define BCRA_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/bcra_pkg.sv =====
// Package with the types, constants and helper functions of the run allocator.
package bcra_pkg;

  // Bitmap geometry.
  localparam int BITMAP_BLOCKS   = 8192;
  localparam int RESERVED_BLOCKS = 6;
  localparam int WORD_W          = 32;
  localparam int WORDS           = BITMAP_BLOCKS / WORD_W;
  localparam int ROW_W           = $clog2(WORDS);
  localparam int WBIT_W          = $clog2(WORD_W);
  localparam int WCNT_W          = ROW_W + 1;
  localparam int LVLS            = WBIT_W;
  localparam int POS_W           = WBIT_W + 1;

  // Field widths.
  localparam int OP_W   = 2;
  localparam int BLK_W  = ROW_W + WBIT_W;
  localparam int CNT_W  = 14;
  localparam int ADDR_W = BLK_W + 1;
  localparam int RUN_W  = CNT_W + 1;

  localparam logic [CNT_W-1:0]  TOTAL_RESET = CNT_W'(BITMAP_BLOCKS);
  localparam logic [WCNT_W-1:0] RESV_W      = WCNT_W'(RESERVED_BLOCKS / WORD_W);
  localparam logic [WBIT_W-1:0] RESV_B      = WBIT_W'(RESERVED_BLOCKS % WORD_W);

  // Request codes.
  localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
  localparam logic [OP_W-1:0] OP_TEST   = 2'd2;
  localparam logic [OP_W-1:0] OP_FORMAT = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MARK,
    ST_TEST_RD,
    ST_TEST_WAIT,
    ST_DONE
  } state_t;

  // Bitmap store read and write requests.
  typedef struct packed {
    logic             en;
    logic [ROW_W-1:0] addr;
  } bm_rd_t;

  typedef struct packed {
    logic              en;
    logic [ROW_W-1:0]  addr;
    logic [WORD_W-1:0] data;
  } bm_wr_t;

  // Outcome of evaluating one bitmap word during a run search.
  typedef struct packed {
    logic             hit;
    logic [BLK_W-1:0] head;
    logic [CNT_W-1:0] run_out;
    logic [BLK_W-1:0] head_out;
  } scan_res_t;

  // Bits of word w that lie at or above the bound bw*WORD_W + bb.
  function automatic logic [WORD_W-1:0] mask_from(input logic [WCNT_W-1:0] w,
                                                  input logic [WCNT_W-1:0] bw,
                                                  input logic [WBIT_W-1:0] bb);
    logic [WORD_W-1:0] m;
    if (w > bw) begin
      m = '1;
    end else if (w == bw) begin
      m = {WORD_W{1'b1}} << bb;
    end else begin
      m = '0;
    end
    return m;
  endfunction

  // Bits of word w that lie below the bound bw*WORD_W + bb.
  function automatic logic [WORD_W-1:0] mask_below(input logic [WCNT_W-1:0] w,
                                                   input logic [WCNT_W-1:0] bw,
                                                   input logic [WBIT_W-1:0] bb);
    logic [WORD_W-1:0] m;
    if (w < bw) begin
      m = '1;
    end else if (w == bw) begin
      m = ~({WORD_W{1'b1}} << bb);
    end else begin
      m = '0;
    end
    return m;
  endfunction

  // Contents of a bitmap row straight after reset or format.
  function automatic logic [WORD_W-1:0] reset_word(input logic [ROW_W-1:0] row);
    return mask_below({1'b0, row}, RESV_W, RESV_B);
  endfunction

  // Number of words needed to cover blocks below v.
  function automatic logic [WCNT_W-1:0] ceil_words(input logic [ADDR_W-1:0] v);
    logic [ADDR_W:0] t;
    t = {1'b0, v} + (ADDR_W+1)'(WORD_W - 1);
    return WCNT_W'(t >> WBIT_W);
  endfunction

endpackage

// ===== hdl/bcra_bitmap.sv =====
// Usage bitmap store: word memory with per-row valid bits and registered read.
module bcra_bitmap import bcra_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fmt,
  input  bm_rd_t            rd,
  input  bm_wr_t            wr,
  output logic [WORD_W-1:0] rd_data
);

  logic [WORD_W-1:0] bitmap_mem_r [WORDS];
  logic [WORD_W-1:0] mem_rd_r;
  logic [WORDS-1:0]  row_valid_r;
  logic              rd_valid_r;
  logic [ROW_W-1:0]  rd_row_r;

  // Memory array: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      bitmap_mem_r[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      mem_rd_r <= bitmap_mem_r[rd.addr];
      rd_row_r <= rd.addr;
    end
  end

  // Row valid bits; a row never written since reset or format holds its reset value.
  always_ff @(posedge clk) begin
    if (!rst_n || fmt) begin
      row_valid_r <= '0;
    end else if (wr.en) begin
      row_valid_r[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else if (rd.en) begin
      rd_valid_r <= row_valid_r[rd.addr];
    end
  end

  assign rd_data = rd_valid_r ? mem_rd_r : reset_word(rd_row_r);

endmodule

// ===== hdl/bcra_word_scan.sv =====
// Run finder for one bitmap word: extends the running free run across 32 blocks.
module bcra_word_scan import bcra_pkg::*; (
  input  logic [WORD_W-1:0] free_bits,
  input  logic [ROW_W-1:0]  row,
  input  logic [CNT_W-1:0]  run_in,
  input  logic [BLK_W-1:0]  head_in,
  input  logic [CNT_W-1:0]  len,
  output scan_res_t         res
);

  logic             has_s [LVLS+1][WORD_W];
  logic [POS_W-1:0] pos_s [LVLS+1][WORD_W];
  logic [RUN_W-1:0] run_len [WORD_W];
  logic [WORD_W-1:0] hit;
  logic [WBIT_W-1:0] sel;
  logic              hit_any;

  // Parallel prefix scan: for each lane, the position just after the last used block.
  always_comb begin
    for (int i = 0; i < WORD_W; i++) begin
      has_s[0][i] = ~free_bits[i];
      pos_s[0][i] = POS_W'(i + 1);
    end
    for (int d = 0; d < LVLS; d++) begin
      for (int i = 0; i < WORD_W; i++) begin
        has_s[d+1][i] = has_s[d][i];
        pos_s[d+1][i] = pos_s[d][i];
      end
      for (int i = (1 << d); i < WORD_W; i++) begin
        if (!has_s[d][i]) begin
          has_s[d+1][i] = has_s[d][i - (1 << d)];
          pos_s[d+1][i] = pos_s[d][i - (1 << d)];
        end
      end
    end
  end

  // Free run length ending at each lane, and the lanes where the run is long enough.
  always_comb begin
    for (int i = 0; i < WORD_W; i++) begin
      if (has_s[LVLS][i]) begin
        run_len[i] = RUN_W'(i + 1) - RUN_W'(pos_s[LVLS][i]);
      end else begin
        run_len[i] = RUN_W'(run_in) + RUN_W'(i + 1);
      end
      hit[i] = (run_len[i] >= RUN_W'(len));
    end
  end

  // Lowest lane that completes the run.
  always_comb begin
    hit_any = 1'b0;
    sel     = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (hit[i]) begin
        hit_any = 1'b1;
        sel     = WBIT_W'(i);
      end
    end
  end

  // First block of the run ending at a given lane.
  function automatic logic [BLK_W-1:0] head_at(input logic [WBIT_W-1:0] k);
    logic [BLK_W-1:0] h;
    if (has_s[LVLS][k]) begin
      h = {row, pos_s[LVLS][k][WBIT_W-1:0]};
    end else if (run_in == '0) begin
      h = {row, {WBIT_W{1'b0}}};
    end else begin
      h = head_in;
    end
    return h;
  endfunction

  always_comb begin
    res.hit      = hit_any;
    res.head     = head_at(sel);
    res.run_out  = run_len[WORD_W-1][CNT_W-1:0];
    res.head_out = head_at(WBIT_W'(WORD_W - 1));
  end

endmodule

// ===== hdl/bitmap_contiguous_run_allocator.sv =====
// Top level of the first-fit contiguous run allocator over a block usage bitmap.
//
// Requests arrive on the in_ channel (valid/ready) with an opcode, a start
// block and a count; each request gives exactly one result on the out_
// channel (valid/ready). cfg_wr_en with cfg_wr_data sets the block total.
// The bitmap is held as 256 words of 32 bits in one memory with one read
// and one write port; a sequencer walks it one word per cycle and a shared
// word evaluator tracks the free run across words.
// Allocate searches W_scan words (up to 256) and then updates the W_mark
// words the run touches; a failed search updates none. Free updates the
// W_mark words of its range. One request is in work at a time, and the
// next can be taken in the same cycle that the result is presented.
// Reset, and a format request, mark the reserved blocks used and all others
// clear through per-row valid bits; no clearing pass is needed.
// The result sits in an output register; while the receiver stalls it holds,
// and the next request is still taken but its result waits behind it.
module bitmap_contiguous_run_allocator import bcra_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [OP_W-1:0]  in_opcode,
  input  logic [BLK_W-1:0] in_start_block,
  input  logic [CNT_W-1:0] in_count,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_status,
  output logic [BLK_W-1:0] out_first_block,
  output logic             out_block_used,
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data
);

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   total_blocks_r;
  logic [CNT_W-1:0]   len_r, len_nxt;
  logic [ADDR_W-1:0]  lo_r, lo_nxt;
  logic [ADDR_W-1:0]  hi_r, hi_nxt;
  logic               set_r, set_nxt;
  logic [WCNT_W-1:0]  rd_w_r, rd_w_nxt;
  logic [WCNT_W-1:0]  end_w_r, end_w_nxt;
  logic [ROW_W-1:0]   proc_w_r, proc_w_nxt;
  logic               pend_r, pend_nxt;
  logic [CNT_W-1:0]   run_r, run_nxt;
  logic [BLK_W-1:0]   head_r, head_nxt;
  logic [BLK_W-1:0]   start_r, start_nxt;
  logic               res_status_r, res_status_nxt;
  logic [BLK_W-1:0]   res_first_r, res_first_nxt;
  logic               res_used_r, res_used_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_status_r, out_status_nxt;
  logic [BLK_W-1:0]   out_first_r, out_first_nxt;
  logic               out_used_r, out_used_nxt;

  logic               accept;
  logic               fmt;
  bm_rd_t             bm_rd;
  bm_wr_t             bm_wr;
  logic [WORD_W-1:0]  bm_data;
  logic [ADDR_W-1:0]  limit;
  logic [WORD_W-1:0]  scan_free;
  logic [WORD_W-1:0]  mark_mask;
  logic [WCNT_W-1:0]  proc_w_ext;
  logic [ADDR_W:0]    free_sum;
  logic [ADDR_W-1:0]  free_hi;
  logic [ADDR_W-1:0]  alloc_hi;
  scan_res_t          scan;

  bcra_bitmap u_bitmap (
    .clk     (clk),
    .rst_n   (rst_n),
    .fmt     (fmt),
    .rd      (bm_rd),
    .wr      (bm_wr),
    .rd_data (bm_data)
  );

  bcra_word_scan u_scan (
    .free_bits (scan_free),
    .row       (proc_w_r),
    .run_in    (run_r),
    .head_in   (head_r),
    .len       (len_r),
    .res       (scan)
  );

  // Search limit saturates to the bitmap size.
  assign limit = (total_blocks_r > ADDR_W'(BITMAP_BLOCKS)) ? ADDR_W'(BITMAP_BLOCKS)
                                                           : total_blocks_r;

  assign proc_w_ext = {1'b0, proc_w_r};

  // Free blocks of the word under search: not used, past the reserved area, below the limit.
  assign scan_free = ~bm_data
                   & mask_from(proc_w_ext, RESV_W, RESV_B)
                   & mask_below(proc_w_ext, limit[ADDR_W-1:WBIT_W], limit[WBIT_W-1:0]);

  // Blocks of the word under update that fall inside the run being marked.
  assign mark_mask = mask_from(proc_w_ext, lo_r[ADDR_W-1:WBIT_W], lo_r[WBIT_W-1:0])
                   & mask_below(proc_w_ext, hi_r[ADDR_W-1:WBIT_W], hi_r[WBIT_W-1:0]);

  // Free run end, clipped to the bitmap.
  assign free_sum = (ADDR_W+1)'(in_start_block) + (ADDR_W+1)'(in_count);
  assign free_hi  = (free_sum > (ADDR_W+1)'(BITMAP_BLOCKS)) ? ADDR_W'(BITMAP_BLOCKS)
                                                             : free_sum[ADDR_W-1:0];
  assign alloc_hi = ADDR_W'(scan.head) + ADDR_W'(len_r);

  assign accept = in_valid && in_ready;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_blocks_r <= TOTAL_RESET;
    end else if (cfg_wr_en) begin
      total_blocks_r <= cfg_wr_data;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk) begin
    len_r        <= len_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    set_r        <= set_nxt;
    rd_w_r       <= rd_w_nxt;
    end_w_r      <= end_w_nxt;
    proc_w_r     <= proc_w_nxt;
    run_r        <= run_nxt;
    head_r       <= head_nxt;
    start_r      <= start_nxt;
    res_status_r <= res_status_nxt;
    res_first_r  <= res_first_nxt;
    res_used_r   <= res_used_nxt;
    out_status_r <= out_status_nxt;
    out_first_r  <= out_first_nxt;
    out_used_r   <= out_used_nxt;
  end

  // Sequencer: next state, memory requests and result updates.
  always_comb begin
    state_nxt      = state_r;
    len_nxt        = len_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    set_nxt        = set_r;
    rd_w_nxt       = rd_w_r;
    end_w_nxt      = end_w_r;
    proc_w_nxt     = proc_w_r;
    pend_nxt       = 1'b0;
    run_nxt        = run_r;
    head_nxt       = head_r;
    start_nxt      = start_r;
    res_status_nxt = res_status_r;
    res_first_nxt  = res_first_r;
    res_used_nxt   = res_used_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_first_nxt  = out_first_r;
    out_used_nxt   = out_used_r;
    fmt            = 1'b0;
    bm_rd.en       = 1'b0;
    bm_rd.addr     = rd_w_r[ROW_W-1:0];
    bm_wr.en       = 1'b0;
    bm_wr.addr     = proc_w_r;
    bm_wr.data     = set_r ? (bm_data | mark_mask) : (bm_data & ~mark_mask);
    in_ready       = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          res_status_nxt = 1'b0;
          res_first_nxt  = '0;
          res_used_nxt   = 1'b0;
          start_nxt      = in_start_block;
          unique case (in_opcode)
            OP_ALLOC: begin
              len_nxt  = in_count;
              run_nxt  = '0;
              head_nxt = '0;
              rd_w_nxt = RESV_W;
              end_w_nxt = ceil_words(limit);
              if (in_count == '0) begin
                res_status_nxt = 1'b1;
                state_nxt      = ST_DONE;
              end else begin
                state_nxt = ST_SCAN;
              end
            end
            OP_FREE: begin
              lo_nxt    = ADDR_W'(in_start_block);
              hi_nxt    = free_hi;
              set_nxt   = 1'b0;
              rd_w_nxt  = WCNT_W'(in_start_block[BLK_W-1:WBIT_W]);
              end_w_nxt = ceil_words(free_hi);
              state_nxt = ST_MARK;
            end
            OP_TEST: begin
              state_nxt = ST_TEST_RD;
            end
            OP_FORMAT: begin
              fmt       = 1'b1;
              state_nxt = ST_DONE;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      // One word read per cycle; the word read last cycle is evaluated now.
      ST_SCAN: begin
        bm_rd.en   = (rd_w_r < end_w_r);
        proc_w_nxt = rd_w_r[ROW_W-1:0];
        pend_nxt   = bm_rd.en;
        if (bm_rd.en) begin
          rd_w_nxt = rd_w_r + WCNT_W'(1);
        end
        if (pend_r && scan.hit) begin
          res_first_nxt = scan.head;
          lo_nxt        = ADDR_W'(scan.head);
          hi_nxt        = alloc_hi;
          set_nxt       = 1'b1;
          rd_w_nxt      = WCNT_W'(scan.head[BLK_W-1:WBIT_W]);
          end_w_nxt     = ceil_words(alloc_hi);
          pend_nxt      = 1'b0;
          state_nxt     = ST_MARK;
        end else if (pend_r) begin
          run_nxt  = scan.run_out;
          head_nxt = scan.head_out;
        end else if (!bm_rd.en) begin
          res_status_nxt = 1'b1;
          state_nxt      = ST_DONE;
        end
      end

      // Read-modify-write of every word the run touches.
      ST_MARK: begin
        bm_rd.en   = (rd_w_r < end_w_r);
        proc_w_nxt = rd_w_r[ROW_W-1:0];
        pend_nxt   = bm_rd.en;
        if (bm_rd.en) begin
          rd_w_nxt = rd_w_r + WCNT_W'(1);
        end
        if (pend_r) begin
          bm_wr.en = 1'b1;
        end else if (!bm_rd.en) begin
          state_nxt = ST_DONE;
        end
      end

      ST_TEST_RD: begin
        bm_rd.en   = 1'b1;
        bm_rd.addr = start_r[BLK_W-1:WBIT_W];
        state_nxt  = ST_TEST_WAIT;
      end

      ST_TEST_WAIT: begin
        res_used_nxt = bm_data[start_r[WBIT_W-1:0]];
        state_nxt    = ST_DONE;
      end

      // Hand the result to the output register once it is free.
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_first_nxt  = res_first_r;
          out_used_nxt   = res_used_r;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_first_block = out_first_r;
  assign out_block_used  = out_used_r;

endmodule

// ===== hdl/bcra_checker.sv =====
// Port-level checker for the run allocator, bound to the top level.
`include "bitmap_contiguous_run_allocator_defines.svh"

module bcra_checker import bcra_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic             out_status,
  input logic [BLK_W-1:0] out_first_block,
  input logic             out_block_used
);

  // A stalled result keeps its valid and its fields.
  `BCRA_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_first_block) && $stable(out_block_used), "stalled result changed")

  // The block works on one request at a time.
  `BCRA_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready, "request taken while busy")

  // A failed allocation carries no block number and no test bit.
  `BCRA_ASSERT(a_fail_fields, out_valid && out_status |-> out_first_block == '0 && !out_block_used, "failure result with payload")

  // Reset leaves the block idle with no result pending.
  `BCRA_ASSERT_RST(a_reset_idle, !rst_n |=> !out_valid && in_ready, "not idle after reset")

endmodule

bind bitmap_contiguous_run_allocator bcra_checker u_bcra_checker (.*);
